// ===== rtl/tccw_pkg.sv =====
// Shared types, constants and character codes of the text console cursor writer.
package tccw_pkg;

   localparam int MAX_COLUMNS = 128;
   localparam int MAX_ROWS    = 64;
   localparam int TAB_SPACES  = 4;

   localparam int COL_W      = 8;
   localparam int ROW_W      = 6;
   localparam int ROWS_CFG_W = 7;
   localparam int GLYPH_W    = 8;
   localparam int COLOR_W    = 4;
   localparam int PUTS_W     = $clog2(TAB_SPACES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [GLYPH_W-1:0] CHAR_RETURN    = 8'd13;
   localparam logic [GLYPH_W-1:0] CHAR_TAB       = 8'd9;
   localparam logic [GLYPH_W-1:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [GLYPH_W-1:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [GLYPH_W-1:0] CHAR_SPACE     = 8'd32;

   localparam logic [1:0] REG_COLUMNS   = 2'd0;
   localparam logic [1:0] REG_ROWS      = 2'd1;
   localparam logic [1:0] REG_ATTRIBUTE = 2'd2;
   localparam logic [1:0] REG_CURSOR_EN = 2'd3;

   typedef enum logic [1:0] {
      ACT_DRAW   = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_SCROLL = 2'd2,
      ACT_REPORT = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      OP_PRINT   = 2'd0,
      OP_RETURN  = 2'd1,
      OP_BACK    = 2'd2,
      OP_NEWLINE = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [GLYPH_W-1:0]  glyph;
      logic [PUTS_W-1:0]   puts;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0]    cols;
      logic [ROW_W-1:0]    last_row;
      logic [COLOR_W-1:0]  fg;
      logic [COLOR_W-1:0]  bg;
      logic                cursor_en;
   } cfg_type;

endpackage

// ===== rtl/text_console_cursor_writer.sv =====
// Text console cursor writer: request queue, command engine and configuration registers.
// A request is queued at acceptance; its first command is then registered in the output stage.
// The engine emits one command per cycle while the output is not stalled. A request has
// 1 command for return, 2 for a printable character (3 with a wrap scroll), up to 9 for a tab.
// Requests are accepted every cycle while the four-entry queue has room.
// Synchronous reset puts the cursor at column 0, row 0, empties the queue and loads defaults.
module text_console_cursor_writer
   import tccw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [GLYPH_W-1:0]    req_glyph_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_action,
   output logic [COL_W-1:0]      rsp_cell_col,
   output logic [ROW_W-1:0]      rsp_cell_row,
   output logic [GLYPH_W-1:0]    rsp_glyph_out,
   output logic [COLOR_W-1:0]    rsp_fg_index,
   output logic [COLOR_W-1:0]    rsp_bg_index,
   output logic                  rsp_cursor_shown,
   output logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   item_type head;
   logic     head_valid;
   logic     pop;

   tccw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tccw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_glyph_in (req_glyph_in),
      .pop          (pop),
      .head_valid   (head_valid),
      .head         (head)
   );

   tccw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_glyph_out    (rsp_glyph_out),
      .rsp_fg_index     (rsp_fg_index),
      .rsp_bg_index     (rsp_bg_index),
      .rsp_cursor_shown (rsp_cursor_shown),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== rtl/tccw_csr.sv =====
// Configuration registers and effective grid limits.
module tccw_csr
   import tccw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [COL_W-1:0]      columns_ff;
   logic [ROWS_CFG_W-1:0] rows_ff;
   logic [7:0]            attribute_ff;
   logic                  cursor_en_ff;
   logic                  write_en;
   logic [1:0]            reg_index;
   logic [COL_W-1:0]      cols_eff;
   logic [ROWS_CFG_W-1:0] rows_eff;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COL_W'(80);
         rows_ff      <= ROWS_CFG_W'(25);
         attribute_ff <= 8'd7;
         cursor_en_ff <= 1'b1;
      end else if (write_en) begin
         unique case (reg_index)
            REG_COLUMNS:   columns_ff   <= csr_pwdata[COL_W-1:0];
            REG_ROWS:      rows_ff      <= csr_pwdata[ROWS_CFG_W-1:0];
            REG_ATTRIBUTE: attribute_ff <= csr_pwdata[7:0];
            REG_CURSOR_EN: cursor_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_COLUMNS:   csr_prdata = CSR_DATA_W'(columns_ff);
         REG_ROWS:      csr_prdata = CSR_DATA_W'(rows_ff);
         REG_ATTRIBUTE: csr_prdata = CSR_DATA_W'(attribute_ff);
         REG_CURSOR_EN: csr_prdata = CSR_DATA_W'(cursor_en_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      priority if (columns_ff == '0) begin
         cols_eff = COL_W'(1);
      end else if (columns_ff > COL_W'(MAX_COLUMNS)) begin
         cols_eff = COL_W'(MAX_COLUMNS);
      end else begin
         cols_eff = columns_ff;
      end
      priority if (rows_ff == '0) begin
         rows_eff = ROWS_CFG_W'(1);
      end else if (rows_ff > ROWS_CFG_W'(MAX_ROWS)) begin
         rows_eff = ROWS_CFG_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_ff;
      end
   end

   assign cfg.cols      = cols_eff;
   assign cfg.last_row  = ROW_W'(rows_eff - ROWS_CFG_W'(1));
   assign cfg.fg        = attribute_ff[3:0];
   assign cfg.bg        = attribute_ff[7:4];
   assign cfg.cursor_en = cursor_en_ff;

endmodule

// ===== rtl/tccw_front.sv =====
// Request intake: classifies characters and queues them for the command engine.
module tccw_front
   import tccw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [GLYPH_W-1:0] req_glyph_in,
   input  logic               pop,
   output logic               head_valid,
   output item_type           head
);

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_in;
   logic                push;
   item_type            item;

   always_comb begin
      item.glyph = req_glyph_in;
      item.puts  = PUTS_W'(1);
      priority if (req_glyph_in == CHAR_RETURN) begin
         item.op = OP_RETURN;
      end else if (req_glyph_in == CHAR_TAB) begin
         item.op    = OP_PRINT;
         item.glyph = CHAR_SPACE;
         item.puts  = PUTS_W'(TAB_SPACES);
      end else if (req_glyph_in == CHAR_BACKSPACE) begin
         item.op = OP_BACK;
      end else if (req_glyph_in == CHAR_NEWLINE) begin
         item.op = OP_NEWLINE;
      end else begin
         item.op = OP_PRINT;
      end
   end

   assign req_stall  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == QCNT_W'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

// ===== rtl/tccw_back.sv =====
// Command engine: walks the cursor and emits one cell command per cycle while the output is not stalled.
module tccw_back
   import tccw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                head_valid,
   input  item_type            head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_action,
   output logic [COL_W-1:0]    rsp_cell_col,
   output logic [ROW_W-1:0]    rsp_cell_row,
   output logic [GLYPH_W-1:0]  rsp_glyph_out,
   output logic [COLOR_W-1:0]  rsp_fg_index,
   output logic [COLOR_W-1:0]  rsp_bg_index,
   output logic                rsp_cursor_shown,
   output logic                rsp_last
);

   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PUTS_W-1:0]   sub_ff, sub_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   action_type          act_ff;
   logic [COL_W-1:0]    out_col_ff;
   logic [ROW_W-1:0]    out_row_ff;
   logic [GLYPH_W-1:0]  out_glyph_ff;
   logic [COLOR_W-1:0]  out_fg_ff;
   logic [COLOR_W-1:0]  out_bg_ff;
   logic                out_shown_ff;
   logic                out_last_ff;

   logic                out_free;
   logic                fire;
   logic                item_end;
   logic                at_last;
   action_type          res_act;
   logic [COL_W-1:0]    res_col;
   logic [ROW_W-1:0]    res_row;
   logic [GLYPH_W-1:0]  res_glyph;
   logic                res_shown;
   logic                res_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = head_valid && out_free;
   assign at_last  = (row_ff >= cfg.last_row);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      sub_in    = sub_ff;
      done_in   = done_ff;
      item_end  = 1'b0;
      res_act   = ACT_REPORT;
      res_col   = col_ff;
      res_row   = row_ff;
      res_glyph = '0;
      res_shown = cfg.cursor_en && (col_ff < cfg.cols);
      res_last  = 1'b1;
      unique case (head.op)
         OP_PRINT: begin
            if (sub_ff < head.puts) begin
               res_last  = 1'b0;
               res_shown = 1'b0;
               if (col_ff >= cfg.cols) begin
                  if (at_last) begin
                     res_act = ACT_SCROLL;
                     res_col = '0;
                     res_row = '0;
                     row_in  = cfg.last_row;
                     col_in  = '0;
                  end else begin
                     res_act   = ACT_DRAW;
                     res_col   = '0;
                     res_row   = ROW_W'(row_ff + 1'b1);
                     res_glyph = head.glyph;
                     row_in    = ROW_W'(row_ff + 1'b1);
                     col_in    = COL_W'(1);
                     sub_in    = PUTS_W'(sub_ff + 1'b1);
                  end
               end else begin
                  res_act   = ACT_DRAW;
                  res_glyph = head.glyph;
                  col_in    = COL_W'(col_ff + 1'b1);
                  sub_in    = PUTS_W'(sub_ff + 1'b1);
               end
            end else begin
               item_end = 1'b1;
            end
         end
         OP_RETURN: begin
            col_in    = '0;
            res_col   = '0;
            res_shown = cfg.cursor_en;
            item_end  = 1'b1;
         end
         OP_NEWLINE: begin
            if (!done_ff && at_last) begin
               res_act   = ACT_SCROLL;
               res_col   = '0;
               res_row   = '0;
               res_shown = 1'b0;
               res_last  = 1'b0;
               row_in    = cfg.last_row;
               col_in    = '0;
               done_in   = 1'b1;
            end else if (!done_ff) begin
               row_in    = ROW_W'(row_ff + 1'b1);
               col_in    = '0;
               res_col   = '0;
               res_row   = ROW_W'(row_ff + 1'b1);
               res_shown = cfg.cursor_en;
               item_end  = 1'b1;
            end else begin
               item_end = 1'b1;
            end
         end
         OP_BACK: begin
            if (!done_ff && col_ff != '0) begin
               res_act   = ACT_ERASE;
               res_col   = COL_W'(col_ff - 1'b1);
               res_shown = 1'b0;
               res_last  = 1'b0;
               col_in    = COL_W'(col_ff - 1'b1);
               done_in   = 1'b1;
            end else if (!done_ff && row_ff != '0) begin
               res_act   = ACT_ERASE;
               res_col   = COL_W'(cfg.cols - 1'b1);
               res_row   = ROW_W'(row_ff - 1'b1);
               res_shown = 1'b0;
               res_last  = 1'b0;
               col_in    = COL_W'(cfg.cols - 1'b1);
               row_in    = ROW_W'(row_ff - 1'b1);
               done_in   = 1'b1;
            end else begin
               item_end = 1'b1;
            end
         end
         default: ;
      endcase
      if (item_end) begin
         sub_in  = '0;
         done_in = 1'b0;
      end
   end

   assign pop          = fire && item_end;
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         sub_ff       <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            sub_ff  <= sub_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         act_ff       <= res_act;
         out_col_ff   <= res_col;
         out_row_ff   <= res_row;
         out_glyph_ff <= res_glyph;
         out_fg_ff    <= cfg.fg;
         out_bg_ff    <= cfg.bg;
         out_shown_ff <= res_shown;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = act_ff;
   assign rsp_cell_col     = out_col_ff;
   assign rsp_cell_row     = out_row_ff;
   assign rsp_glyph_out    = out_glyph_ff;
   assign rsp_fg_index     = out_fg_ff;
   assign rsp_bg_index     = out_bg_ff;
   assign rsp_cursor_shown = out_shown_ff;
   assign rsp_last         = out_last_ff;

   a_scroll_pins_row: assert property (@(posedge clock) disable iff (reset)
      (fire && res_act == ACT_SCROLL) |=> row_ff == cfg.last_row)
      else $error("cursor row not on last row after scroll");

   a_pop_clears_step: assert property (@(posedge clock) disable iff (reset)
      pop |=> (sub_ff == '0) && !done_ff)
      else $error("step state not cleared after request completed");

   a_draw_inside: assert property (@(posedge clock) disable iff (reset)
      (fire && res_act == ACT_DRAW) |-> res_col < cfg.cols)
      else $error("draw outside the grid");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the text console cursor writer with its own cursor tracker.
`timescale 1ns / 100ps

module testbench;
   import tccw_pkg::*;

   typedef struct {
      action_type         action;
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [GLYPH_W-1:0] glyph;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic               shown;
      logic               last;
   } cell_cmd_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [GLYPH_W-1:0]    req_glyph_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_action;
   logic [COL_W-1:0]      rsp_cell_col;
   logic [ROW_W-1:0]      rsp_cell_row;
   logic [GLYPH_W-1:0]    rsp_glyph_out;
   logic [COLOR_W-1:0]    rsp_fg_index;
   logic [COLOR_W-1:0]    rsp_bg_index;
   logic                  rsp_cursor_shown;
   logic                  rsp_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cell_cmd_type pending_cmds[$];
   int           mismatch_count = 0;
   bit           idle_on = 1'b1;
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;

   logic [7:0] shadow_cols = 8'd80;
   logic [6:0] shadow_rows = 7'd25;
   logic [7:0] shadow_attr = 8'd7;
   logic       shadow_cursor_en = 1'b1;
   int         track_col = 0;
   int         track_row = 0;

   text_console_cursor_writer dut (.*);

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int visible_cols();
      int c = shadow_cols;
      if (c == 0) c = 1;
      if (c > MAX_COLUMNS) c = MAX_COLUMNS;
      return c;
   endfunction

   function automatic int visible_rows();
      int r = shadow_rows;
      if (r == 0) r = 1;
      if (r > MAX_ROWS) r = MAX_ROWS;
      return r;
   endfunction

   function automatic void push_cmd(action_type act, int col, int row, int glyph,
                                    logic shown, logic last);
      cell_cmd_type c;
      c.action = act;
      c.col    = col[COL_W-1:0];
      c.row    = row[ROW_W-1:0];
      c.glyph  = glyph[GLYPH_W-1:0];
      c.fg     = shadow_attr[3:0];
      c.bg     = shadow_attr[7:4];
      c.shown  = shown;
      c.last   = last;
      pending_cmds.push_back(c);
   endfunction

   function automatic void line_feed();
      int rows = visible_rows();
      if (track_row >= rows - 1) begin
         push_cmd(ACT_SCROLL, 0, 0, 0, 1'b0, 1'b0);
         track_row = rows - 1;
      end else begin
         track_row++;
      end
      track_col = 0;
   endfunction

   function automatic void print_char(int ch);
      if (track_col >= visible_cols()) line_feed();
      push_cmd(ACT_DRAW, track_col, track_row, ch, 1'b0, 1'b0);
      track_col = (track_col + 1) & 255;
   endfunction

   function automatic void track_glyph(logic [GLYPH_W-1:0] ch);
      logic shown;
      if (ch == CHAR_RETURN) begin
         track_col = 0;
      end else if (ch == CHAR_TAB) begin
         for (int i = 0; i < TAB_SPACES; i++) print_char(CHAR_SPACE);
      end else if (ch == CHAR_BACKSPACE) begin
         if (track_col > 0) begin
            track_col--;
            push_cmd(ACT_ERASE, track_col, track_row, 0, 1'b0, 1'b0);
         end else if (track_row > 0) begin
            track_col = visible_cols() - 1;
            track_row--;
            push_cmd(ACT_ERASE, track_col, track_row, 0, 1'b0, 1'b0);
         end
      end else if (ch == CHAR_NEWLINE) begin
         line_feed();
      end else begin
         print_char(ch);
      end
      shown = shadow_cursor_en && (track_col < visible_cols());
      push_cmd(ACT_REPORT, track_col, track_row, 0, shown, 1'b1);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= 80;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(0, 99) < 21);
      end
   end

   task automatic check_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      cell_cmd_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            $error("result with no request waiting for it");
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("action", want.action, rsp_action);
            check_field("cell_col", want.col, rsp_cell_col);
            check_field("cell_row", want.row, rsp_cell_row);
            check_field("glyph_out", want.glyph, rsp_glyph_out);
            check_field("fg_index", want.fg, rsp_fg_index);
            check_field("bg_index", want.bg, rsp_bg_index);
            check_field("cursor_shown", want.shown, rsp_cursor_shown);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   task automatic send_glyph(logic [GLYPH_W-1:0] g);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 21) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid    <= 1'b1;
      req_glyph_in <= g;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_glyph(g);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_COLUMNS:   shadow_cols = value[7:0];
         REG_ROWS:      shadow_rows = value[6:0];
         REG_ATTRIBUTE: shadow_attr = value[7:0];
         REG_CURSOR_EN: shadow_cursor_en = value[0];
         default: ;
      endcase
   endtask

   task automatic set_grid(int cols, int rows);
      drain_results();
      write_register(REG_COLUMNS, cols);
      write_register(REG_ROWS, rows);
   endtask

   function automatic logic [GLYPH_W-1:0] random_glyph();
      int r = $urandom_range(0, 99);
      if (r < 45) return GLYPH_W'($urandom_range(0, 255));
      if (r < 60) return CHAR_TAB;
      if (r < 75) return CHAR_NEWLINE;
      if (r < 88) return CHAR_BACKSPACE;
      return CHAR_RETURN;
   endfunction

   task automatic test_controls();
      send_glyph(CHAR_BACKSPACE);
      send_glyph(8'h00);
      send_glyph(8'hFF);
      send_glyph("A");
      send_glyph(CHAR_TAB);
      send_glyph(CHAR_BACKSPACE);
      send_glyph(CHAR_RETURN);
      send_glyph(CHAR_BACKSPACE);
      send_glyph(CHAR_NEWLINE);
      send_glyph(CHAR_BACKSPACE);
      send_glyph(8'h7F);
      send_glyph(8'h55);
      send_glyph(8'hAA);
   endtask

   task automatic test_colors_and_cursor();
      drain_results();
      write_register(REG_CURSOR_EN, 32'h0);
      write_register(REG_ATTRIBUTE, 32'hF0);
      send_glyph("x");
      send_glyph(CHAR_RETURN);
      drain_results();
      write_register(REG_CURSOR_EN, 32'h1);
      write_register(REG_ATTRIBUTE, 32'h0F);
      send_glyph("y");
   endtask

   task automatic test_tiny_grid();
      set_grid(1, 1);
      send_glyph("p");
      send_glyph("q");
      send_glyph(CHAR_TAB);
      send_glyph(CHAR_NEWLINE);
      send_glyph(CHAR_BACKSPACE);
      set_grid(0, 0);
      send_glyph("r");
      send_glyph(CHAR_TAB);
      send_glyph(CHAR_NEWLINE);
   endtask

   task automatic test_full_width();
      set_grid(255, 127);
      send_glyph(CHAR_RETURN);
      for (int i = 0; i < MAX_COLUMNS / TAB_SPACES; i++) send_glyph(CHAR_TAB);
      send_glyph(CHAR_BACKSPACE);
      send_glyph("z");
      send_glyph("q");
   endtask

   task automatic test_shrunken_grid();
      set_grid(128, 64);
      for (int i = 0; i < 5; i++) send_glyph(CHAR_NEWLINE);
      for (int i = 0; i < 8; i++) send_glyph(CHAR_TAB);
      set_grid(5, 3);
      send_glyph(CHAR_BACKSPACE);
      send_glyph("c");
      set_grid(10, 64);
      for (int i = 0; i < 3; i++) send_glyph(CHAR_NEWLINE);
      set_grid(10, 2);
      send_glyph(CHAR_NEWLINE);
   endtask

   task automatic test_back_pressure();
      drain_results();
      write_register(REG_COLUMNS, 6);
      write_register(REG_ROWS, 3);
      idle_on = 1'b0;
      hold_requests++;
      for (int i = 0; i < 24; i++) send_glyph(random_glyph());
      drain_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random_phases();
      int cols;
      int rows;
      for (int p = 0; p < 8; p++) begin
         case ($urandom_range(0, 5))
            0: cols = 0;
            1: cols = 1;
            2, 3: cols = $urandom_range(2, 8);
            4: cols = $urandom_range(0, 255);
            default: cols = $urandom_range(0, 1) ? 128 : 255;
         endcase
         case ($urandom_range(0, 5))
            0: rows = 0;
            1: rows = 1;
            2, 3: rows = $urandom_range(2, 6);
            4: rows = $urandom_range(0, 127);
            default: rows = $urandom_range(0, 1) ? 64 : 127;
         endcase
         drain_results();
         write_register(REG_COLUMNS,
                        (CSR_DATA_W'($urandom_range(0, 255)) << 8) | CSR_DATA_W'(cols));
         write_register(REG_ROWS,
                        (CSR_DATA_W'($urandom_range(0, 255)) << 7) | CSR_DATA_W'(rows));
         write_register(REG_ATTRIBUTE, $urandom);
         write_register(REG_CURSOR_EN, $urandom);
         idle_on = (p != 3);
         for (int i = 0; i < 16; i++) send_glyph(random_glyph());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_controls();
      test_colors_and_cursor();
      test_tiny_grid();
      test_full_width();
      test_shrunken_grid();
      test_back_pressure();
      test_random_phases();
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
